// ----- sv/dad_pkg.sv -----
package dad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned ADD_W   = 15;

  // Running remainder: day + count + days of the months before the start month.
  localparam int unsigned REM_W   = 16;
  // Year during the walk carries past the field range without wrapping.
  localparam int unsigned YACC_W  = YEAR_W + 1;
  // Year modulo the 400-year cycle.
  localparam int unsigned CYC_W   = 9;
  localparam int unsigned LEN_W   = 5;

  localparam logic [CYC_W-1:0]   YEARS_PER_CYCLE = CYC_W'(400);
  localparam logic [CYC_W-1:0]   CYC_LAST        = CYC_W'(399);
  localparam logic [CYC_W-1:0]   CENT_1          = CYC_W'(100);
  localparam logic [CYC_W-1:0]   CENT_2          = CYC_W'(200);
  localparam logic [CYC_W-1:0]   CENT_3          = CYC_W'(300);
  localparam logic [MONTH_W-1:0] MONTH_JAN       = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC       = MONTH_W'(12);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ACCUM,
    ST_WALK,
    ST_DONE
  } dad_state_t;

  // Length of month m; leap selects 29 days for February.
  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    case (m)
      4'd2:                     len = leap ? LEN_W'(29) : LEN_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:  len = LEN_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
                                len = LEN_W'(31);
      default:                  len = '0;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/date_add_days.sv -----
// Gregorian date plus a count of days.
//
// Input channel: drive in_start_day, in_start_month, in_start_year and
// in_days_to_add with start high; the beat is taken at the rising edge where
// start is high and busy is low. busy stays high from the next cycle until
// the result has been shown.
// Result channel: out_end_day, out_end_month and out_end_year are valid for
// exactly one cycle, marked by out_valid. The receiver cannot stall; it must
// take the beat in that cycle. Exactly one result per input beat.
// One shared add/subtract unit under a small sequencer does the stepwise work:
//   - year reduction mod 400: one subtract per cycle
//   - months before the start month: one add per cycle
//   - month walk: one month per cycle
//   - a final state to present the result
// No new beat is taken until the result has been shown; a new beat may
// follow in the cycle after out_valid.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// item in progress; no result is produced for it.
module date_add_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dad_pkg::DAY_W-1:0]     in_start_day,
  input  logic [dad_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [dad_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [dad_pkg::ADD_W-1:0]     in_days_to_add,
  output logic                          out_valid,
  output logic [dad_pkg::DAY_W-1:0]     out_end_day,
  output logic [dad_pkg::MONTH_W-1:0]   out_end_month,
  output logic [dad_pkg::YEAR_W-1:0]    out_end_year
);
  import dad_pkg::*;

  dad_state_t          state_r, state_nxt;
  logic [REM_W-1:0]    rem_r;      // remainder; also holds the year during reduction
  logic [MONTH_W-1:0]  mon_r;      // month counter
  logic [MONTH_W-1:0]  lim_r;      // clamped start month
  logic [YACC_W-1:0]   year_r;
  logic [CYC_W-1:0]    cyc_r;      // year mod 400

  // Hold the day and count while the year is reduced.
  logic [DAY_W-1:0]    day_hold_r;
  logic [ADD_W-1:0]    add_hold_r;

  logic                accept;
  logic                leap;
  logic [LEN_W-1:0]    len;

  // Shared add/subtract unit.
  logic [REM_W-1:0]    op_a;
  logic [REM_W-1:0]    op_b;
  logic                op_sub;
  logic [REM_W:0]      op_res;
  logic                borrow;
  logic                walk_more;

  assign accept = start && !busy;

  // Leap test on the year's place in the 400-year cycle.
  assign leap = (cyc_r == '0) ||
                ((cyc_r[1:0] == 2'b00) && (cyc_r != CENT_1) &&
                 (cyc_r != CENT_2) && (cyc_r != CENT_3));
  assign len  = month_len(mon_r, leap);

  assign op_res    = op_sub ? ({1'b0, op_a} - {1'b0, op_b})
                            : ({1'b0, op_a} + {1'b0, op_b});
  assign borrow    = op_sub && op_res[REM_W];
  // Walk on while the month is shorter than the remainder.
  assign walk_more = !borrow && (op_res[REM_W-1:0] != '0);

  // Outputs of the sequencer: operand routing and handshake.
  always_comb begin
    op_a   = rem_r;
    op_b   = REM_W'(len);
    op_sub = 1'b1;
    busy   = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    case (state_r)
      ST_REDUCE: begin
        op_b = REM_W'(YEARS_PER_CYCLE);
      end
      ST_ACCUM: begin
        op_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_REDUCE;
      ST_REDUCE: if (borrow) state_nxt = ST_ACCUM;
      ST_ACCUM:  if (mon_r >= lim_r) state_nxt = ST_WALK;
      ST_WALK:   if (!walk_more) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Reduce the year in rem_r first; day and count wait in the hold
          // registers below.
          rem_r  <= REM_W'(in_start_year);
          year_r <= YACC_W'(in_start_year);
          lim_r  <= (in_start_month > MONTH_DEC) ? MONTH_DEC : in_start_month;
          mon_r  <= MONTH_JAN;
          cyc_r  <= '0;
        end
      end
      ST_REDUCE: begin
        if (borrow) begin
          // Remainder below 400: it is the cycle position. Load day + count.
          cyc_r <= rem_r[CYC_W-1:0];
          rem_r <= REM_W'(day_hold_r) + REM_W'(add_hold_r);
        end else begin
          rem_r <= op_res[REM_W-1:0];
        end
      end
      ST_ACCUM: begin
        if (mon_r < lim_r) begin
          rem_r <= op_res[REM_W-1:0];
          mon_r <= mon_r + MONTH_W'(1);
        end else begin
          mon_r <= MONTH_JAN;
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          rem_r <= op_res[REM_W-1:0];
          if (mon_r == MONTH_DEC) begin
            mon_r  <= MONTH_JAN;
            year_r <= year_r + YACC_W'(1);
            cyc_r  <= (cyc_r == CYC_LAST) ? '0 : cyc_r + CYC_W'(1);
          end else begin
            mon_r <= mon_r + MONTH_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      day_hold_r <= in_start_day;
      add_hold_r <= in_days_to_add;
    end
  end

  assign out_end_day   = rem_r[DAY_W-1:0];
  assign out_end_month = mon_r;
  assign out_end_year  = year_r[YEAR_W-1:0];

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // A result is shown for a single cycle only.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // The month counter stays in range throughout the walk.
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_DONE) |->
      (mon_r >= MONTH_JAN && mon_r <= MONTH_DEC))
    else $error("month counter out of range");

  // Cycle position stays below 400 once the walk has begun.
  a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cyc_r <= CYC_LAST))
    else $error("year cycle position out of range");

endmodule

// ----- dv/tb_date_add_days.sv -----
module tb_date_add_days;

  import dad_pkg::*;

  // One input beat as the sender sees it. pause_first makes the sender hold
  // this beat back until every outstanding result has come home.
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add;
    bit                 pause_first;
  } date_req_t;

  // One result beat.
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_res_t;

  localparam int unsigned DAYS_IN_MONTH [1:12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};
  localparam int unsigned MONTHS_IN_YEAR = 12;
  // Quiet cycles after the last result: covers the longest item in flight.
  localparam int unsigned DRAIN_CYCLES = 1200;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [DAY_W-1:0]   in_start_day   = '0;
  logic [MONTH_W-1:0] in_start_month = '0;
  logic [YEAR_W-1:0]  in_start_year  = '0;
  logic [ADD_W-1:0]   in_days_to_add = '0;
  logic               out_valid;
  logic [DAY_W-1:0]   out_end_day;
  logic [MONTH_W-1:0] out_end_month;
  logic [YEAR_W-1:0]  out_end_year;

  date_req_t pending_dates[$];
  date_res_t expected_dates[$];
  date_req_t cur_req;
  date_res_t got_date;

  int unsigned gap_left    = 0;
  int unsigned burst_left  = 1;
  int unsigned n_accepted  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_mismatch  = 0;
  bit          next_start;

  date_add_days dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_days_to_add (in_days_to_add),
    .out_valid      (out_valid),
    .out_end_day    (out_end_day),
    .out_end_month  (out_end_month),
    .out_end_year   (out_end_year)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gregorian 4/100/400 rule, judged on the full-precision year.
  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_of(input int unsigned y, input int unsigned m);
    if (m < 1 || m > MONTHS_IN_YEAR) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    return DAYS_IN_MONTH[m];
  endfunction

  // Expected end date: fold the start date into a day-of-year remainder, then
  // peel off whole months from January of the start year.
  function automatic date_res_t advance_date(input date_req_t r);
    int unsigned remain;
    int unsigned mon;
    int unsigned yr;
    int unsigned first_mon;
    date_res_t   res;
    first_mon = (r.month > MONTHS_IN_YEAR) ? MONTHS_IN_YEAR : r.month;
    yr        = r.year;
    remain    = r.day + r.add;
    for (int unsigned m = 1; m < first_mon; m++) remain += days_of(yr, m);
    mon = 1;
    while (days_of(yr, mon) < remain) begin
      remain -= days_of(yr, mon);
      mon++;
      if (mon > MONTHS_IN_YEAR) begin
        mon = 1;
        yr++;
      end
    end
    res.day   = remain[DAY_W-1:0];
    res.month = mon[MONTH_W-1:0];
    res.year  = yr[YEAR_W-1:0];
    return res;
  endfunction

  task automatic queue_date(input int unsigned d, input int unsigned m,
                            input int unsigned y, input int unsigned a,
                            input bit pause_first = 1'b0);
    date_req_t r;
    r.day         = d[DAY_W-1:0];
    r.month       = m[MONTH_W-1:0];
    r.year        = y[YEAR_W-1:0];
    r.add         = a[ADD_W-1:0];
    r.pause_first = pause_first;
    pending_dates.push_back(r);
  endtask

  // Sender. A beat moves at the edge where start is high and busy is low.
  // After each beat, either launch the next one straight away or idle for a
  // gap; bursts of random length alternate with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        // Beat taken: record what the block must answer.
        expected_dates.push_back(advance_date(cur_req));
        n_accepted++;
        next_start = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_dates.size() > 0) begin
          // Hold a pausing beat until the result queue has drained. Skip the
          // edge carrying a result so the check does not race the monitor.
          if (!pending_dates[0].pause_first ||
              (expected_dates.size() == 0 && !out_valid)) begin
            cur_req        = pending_dates.pop_front();
            in_start_day   <= cur_req.day;
            in_start_month <= cur_req.month;
            in_start_year  <= cur_req.year;
            in_days_to_add <= cur_req.add;
            next_start     = 1'b1;
          end
        end
      end
      // Single update per edge, so a back-to-back beat keeps start high.
      start <= next_start;
    end
  end

  // Receiver. It can never stall; every strobed result is compared against
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        $error("result with nothing outstanding: day %0d month %0d year %0d",
               out_end_day, out_end_month, out_end_year);
        n_mismatch++;
      end else begin
        got_date = expected_dates.pop_front();
        n_checked++;
        if (out_end_day !== got_date.day) begin
          $error("end_day mismatch: expected %0d, actual %0d", got_date.day, out_end_day);
          n_mismatch++;
        end
        if (out_end_month !== got_date.month) begin
          $error("end_month mismatch: expected %0d, actual %0d",
                 got_date.month, out_end_month);
          n_mismatch++;
        end
        if (out_end_year !== got_date.year) begin
          $error("end_year mismatch: expected %0d, actual %0d",
                 got_date.year, out_end_year);
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned a;
    int unsigned odd_years [6] = '{0, 1900, 2000, 2100, 2400, 9900};

    // Directed beats: field extremes and the odd corners of the calendar.
    queue_date(1, 1, 2000, 0);          // nothing added
    queue_date(0, 0, 0, 0);             // all fields zero
    queue_date(0, 1, 2024, 0);          // day zero, nothing added
    queue_date(31, 12, 9999, 32767);    // top of the nominal ranges
    queue_date(31, 15, 16383, 32767);   // every input bit set
    queue_date(1, 1, 16383, 32767);     // year walks past the field width
    queue_date(5, 0, 2023, 100);        // month zero
    queue_date(10, 13, 2023, 50);       // month above twelve
    queue_date(10, 15, 2023, 0);
    queue_date(31, 2, 2023, 10);        // day past the month's end
    queue_date(31, 4, 2023, 0);
    queue_date(28, 2, 2000, 1, 1'b1);   // 400-year leap, sent after a drain
    queue_date(28, 2, 1900, 1);         // century, not leap
    queue_date(28, 2, 2024, 1);
    queue_date(28, 2, 2023, 1);
    queue_date(29, 2, 2096, 1461);
    queue_date(31, 12, 1999, 1);        // year rollover
    queue_date(1, 3, 2100, 365);
    queue_date(31, 1, 0, 32767);
    queue_date(30, 11, 9999, 32767);

    // Random beats: mostly proper dates, some calendar corners, some noise.
    for (int i = 0; i < 540; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        m = $urandom_range(1, 12);
        y = $urandom_range(0, 9999);
        d = $urandom_range(1, days_of(y, m));
        case ($urandom_range(0, 3))
          0:       a = $urandom_range(0, 400);
          1:       a = $urandom_range(0, 40);
          default: a = $urandom_range(0, 32767);
        endcase
      end else if (pick < 85) begin
        // Month ends and February around century and 400-year boundaries.
        y = odd_years[$urandom_range(0, 5)] + $urandom_range(0, 4);
        m = ($urandom_range(0, 1) == 0) ? 2 : $urandom_range(1, 12);
        d = days_of(y, m) - $urandom_range(0, 1);
        a = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3);
      end else begin
        // Raw bits over the full width of every field.
        d = $urandom;
        m = $urandom;
        y = $urandom;
        a = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 60);
      end
      queue_date(d, m, y, a, (i % 137) == 68);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every beat sent, every result back, then a quiet stretch.
    while (pending_dates.size() != 0 || start) @(negedge clk);
    while (expected_dates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_dates.size() != 0) begin
      $error("%0d results never arrived", expected_dates.size());
      n_mismatch++;
    end
    $display("Sent %0d dates (calendar corners, malformed fields, random spans);",
             n_accepted);
    $display("compared %0d end dates, %0d field errors.", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb_date_add_days passed");
    end else begin
      $display("tb_date_add_days failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40000000;
    $display("tb_date_add_days failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dad_pkg.sv
sv/date_add_days.sv
dv/tb_date_add_days.sv
